@@ rtl/core/mbet_pkg.sv @@
package mbet_pkg;

    // Field widths of the ports
    localparam int FIELD_W       = 32;
    localparam int COUNT_FIELD_W = 24;

    // Fixed-point format of z and c
    localparam int FRAC_BITS = 28;

    // Default iteration counter width and budget after reset
    localparam int COUNT_BITS_DEF = 24;
    localparam int RESET_BUDGET   = 1048576;

    // Multiplier operand: a magnitude below 2.0 while the loop runs
    localparam int MUL_W  = FRAC_BITS + 1;
    localparam int PROD_W = 2 * MUL_W;
    // Square of a component, up to 4.0 when saturated
    localparam int SQ_W   = FRAC_BITS + 3;
    // z components: c plus a cross term below 8.0, plus sign and headroom
    localparam int Z_W    = ((SQ_W > FIELD_W) ? SQ_W : FIELD_W) + 2;

    localparam logic [SQ_W-1:0] FOUR_FX = {1'b1, {(FRAC_BITS + 2){1'b0}}};

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR,
        ST_SQI,
        ST_CROSS,
        ST_UPD,
        ST_DONE
    } mbet_state_t;

endpackage

@@ rtl/core/mandelbrot_escape_time.sv @@
// Escape-time counter for one complex point c per beat.
// Input channel (s_valid/s_ready): s_point_real and s_point_imag, signed fixed
// point with FRAC_BITS fraction bits. The iteration starts at z = c and runs
// z = z^2 + c while |z|^2 < 4.0 and the budget is not used up.
// Result channel (m_valid/m_ready): m_iteration_count, the number of updates
// done, equal to the budget when the point does not escape.
// Configuration: cfg_we writes the budget from cfg_wdata; write
// it only while no point is in flight.
// Multiplier: one 29x29 multiplier is shared by the three products of an
// iteration, computed in turn in the SQR, SQI and CROSS states before the
// UPD state checks for escape. The next point is accepted only after the
// previous one has reached the done state and gone back to idle.
// The result sits in an output register: a new point is accepted while the
// previous result still waits; a second result waits in the done state
// until the receiver takes the first.
// Reset (aresetn low, synchronous) returns to idle, drops m_valid and loads
// a budget of 1048576 iterations.
module mandelbrot_escape_time
    import mbet_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [COUNT_FIELD_W-1:0]        cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [FIELD_W-1:0]       s_point_real,
    input  logic signed [FIELD_W-1:0]       s_point_imag,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [COUNT_FIELD_W-1:0]        m_iteration_count
);

    localparam int CNT_W = (COUNT_BITS < COUNT_FIELD_W) ? COUNT_BITS : COUNT_FIELD_W;

    mbet_state_t state_reg, state_next;

    logic [CNT_W-1:0]         budget_reg;
    logic [CNT_W-1:0]         iter_reg, iter_next;
    logic [CNT_W-1:0]         result_reg, result_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [Z_W-1:0]    zr_reg, zr_next;
    logic signed [Z_W-1:0]    zi_reg, zi_next;
    logic signed [FIELD_W-1:0] cr_reg, cr_next;
    logic signed [FIELD_W-1:0] ci_reg, ci_next;
    logic [SQ_W-1:0]          zr2_reg, zr2_next;
    logic [SQ_W-1:0]          zi2_reg, zi2_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;

    // Sequencer outputs
    logic                     load_point;
    logic                     ld_zr2;
    logic                     ld_zi2;
    logic                     step;
    logic                     out_load;
    logic                     sel_a_imag;
    logic                     sel_b_imag;

    // Datapath terms
    logic [Z_W-1:0]           mag_r, mag_i;
    logic                     sat_r, sat_i;
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic [SQ_W-1:0]          sq_from_prod;
    logic [SQ_W:0]            mag_sum;
    logic                     finish;
    logic signed [Z_W-1:0]    cross_mag, cross_s;

    // Magnitudes and escape flags of the current z
    always_comb begin
        mag_r = zr_reg[Z_W-1] ? Z_W'(-zr_reg) : Z_W'(zr_reg);
        mag_i = zi_reg[Z_W-1] ? Z_W'(-zi_reg) : Z_W'(zi_reg);
        sat_r = |mag_r[Z_W-1:FRAC_BITS+1];
        sat_i = |mag_i[Z_W-1:FRAC_BITS+1];
    end

    // Shared multiplier operands: r*r, then i*i, then r*i
    assign mul_a = sel_a_imag ? mag_i[MUL_W-1:0] : mag_r[MUL_W-1:0];
    assign mul_b = sel_b_imag ? mag_i[MUL_W-1:0] : mag_r[MUL_W-1:0];

    // Square truncated to FRAC_BITS fraction bits
    assign sq_from_prod = {1'b0, prod_reg[PROD_W-1:FRAC_BITS]};

    // Bailout and budget check
    assign mag_sum = {1'b0, zr2_reg} + {1'b0, zi2_reg};
    assign finish  = (iter_reg == budget_reg) || (mag_sum >= {1'b0, FOUR_FX});

    // Cross term 2*zr*zi, truncated toward zero, then signed
    always_comb begin
        cross_mag = $signed(Z_W'(prod_reg[PROD_W-1:FRAC_BITS-1]));
        cross_s   = (zr_reg[Z_W-1] ^ zi_reg[Z_W-1]) ? -cross_mag : cross_mag;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_SQR;
            ST_SQR:   state_next = ST_SQI;
            ST_SQI:   state_next = ST_CROSS;
            ST_CROSS: state_next = ST_UPD;
            ST_UPD:   state_next = finish ? ST_DONE : ST_SQR;
            ST_DONE:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready    = 1'b0;
        load_point = 1'b0;
        ld_zr2     = 1'b0;
        ld_zi2     = 1'b0;
        step       = 1'b0;
        out_load   = 1'b0;
        sel_a_imag = 1'b0;
        sel_b_imag = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                load_point = s_valid;
            end
            ST_SQR: begin
            end
            ST_SQI: begin
                ld_zr2     = 1'b1;
                sel_a_imag = 1'b1;
                sel_b_imag = 1'b1;
            end
            ST_CROSS: begin
                ld_zi2     = 1'b1;
                sel_b_imag = 1'b1;
            end
            ST_UPD: begin
                step = !finish;
            end
            ST_DONE: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        zr_next      = zr_reg;
        zi_next      = zi_reg;
        cr_next      = cr_reg;
        ci_next      = ci_reg;
        zr2_next     = zr2_reg;
        zi2_next     = zi2_reg;
        iter_next    = iter_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg;
        prod_next    = PROD_W'(mul_a) * PROD_W'(mul_b);

        if (load_point) begin
            cr_next   = s_point_real;
            ci_next   = s_point_imag;
            zr_next   = Z_W'(s_point_real);
            zi_next   = Z_W'(s_point_imag);
            iter_next = '0;
        end
        if (ld_zr2) begin
            zr2_next = sat_r ? FOUR_FX : sq_from_prod;
        end
        if (ld_zi2) begin
            zi2_next = sat_i ? FOUR_FX : sq_from_prod;
        end
        // z = z^2 + c
        if (step) begin
            zi_next   = cross_s + Z_W'(ci_reg);
            zr_next   = $signed(Z_W'(zr2_reg)) - $signed(Z_W'(zi2_reg)) + Z_W'(cr_reg);
            iter_next = iter_reg + 1'b1;
        end

        // Output register
        if (out_load) begin
            result_next  = iter_reg;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            budget_reg  <= CNT_W'(RESET_BUDGET);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                budget_reg <= cfg_wdata[CNT_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        zr_reg     <= zr_next;
        zi_reg     <= zi_next;
        cr_reg     <= cr_next;
        ci_reg     <= ci_next;
        zr2_reg    <= zr2_next;
        zi2_reg    <= zi2_next;
        iter_reg   <= iter_next;
        result_reg <= result_next;
        prod_reg   <= prod_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_iteration_count = COUNT_FIELD_W'(result_reg);

    // A point is worked on alone: no second beat right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a point is in flight");

    // Each continued iteration restarts the multiply sequence and bumps the count
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPD && !finish |=>
            state_reg == ST_SQR && iter_reg == $past(iter_reg) + 1'b1)
        else $error("iteration step lost");

    // A result appears only from the done state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

endmodule
